// ===== design/psma_pkg.sv =====
// ----------------------------------------------------------------------------
// psma_pkg
// Shared widths, codes and types of the Pauli string accumulate block.
// ----------------------------------------------------------------------------
package psma_pkg;

   localparam int INDEX_BITS  = 10;
   localparam int AMP_WIDTH   = 24;
   localparam int COEFF_WIDTH = 16;
   localparam int DEPTH       = 1 << INDEX_BITS;
   localparam int ENTRY_W     = 2 * AMP_WIDTH;

   // coefficient after phase rotation needs one more bit for the negated minimum
   localparam int CW        = COEFF_WIDTH + 1;
   localparam int PROD_W    = CW + AMP_WIDTH;
   localparam int DIFF_W    = PROD_W + 1;
   localparam int RND_SHIFT = 12;
   localparam int RND_W     = DIFF_W + 1 - RND_SHIFT;
   localparam int ACC_W     = RND_W + 1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = (INDEX_BITS > COEFF_WIDTH) ? INDEX_BITS : COEFF_WIDTH;

   localparam logic signed [COEFF_WIDTH-1:0] COEFF_RE_RESET = COEFF_WIDTH'(4096);
   localparam logic signed [AMP_WIDTH-1:0]   AMP_MAX = {1'b0, {(AMP_WIDTH-1){1'b1}}};
   localparam logic signed [AMP_WIDTH-1:0]   AMP_MIN = {1'b1, {(AMP_WIDTH-1){1'b0}}};

   typedef logic [1:0] op_type;
   localparam op_type OP_ACC   = 2'd0;
   localparam op_type OP_WRITE = 2'd1;
   localparam op_type OP_READ  = 2'd2;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_FLIP     = 3'd0;
   localparam csr_index_type CSR_Y        = 3'd1;
   localparam csr_index_type CSR_Z        = 3'd2;
   localparam csr_index_type CSR_COEFF_RE = 3'd3;
   localparam csr_index_type CSR_COEFF_IM = 3'd4;

   typedef struct packed {
      logic mul_en;
      logic rnd_en;
   } arith_ctrl_type;

endpackage

// ===== design/psma_ram.sv =====
// ----------------------------------------------------------------------------
// psma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== design/psma_arith.sv =====
// ----------------------------------------------------------------------------
// psma_arith
// Complex multiply, round to Q8.15 and saturating add into the stored entry.
// ----------------------------------------------------------------------------
module psma_arith
   import psma_pkg::*;
(
   input  logic                        clock,
   input  arith_ctrl_type              ctrl,
   input  logic signed [CW-1:0]        cr,
   input  logic signed [CW-1:0]        ci,
   input  logic signed [AMP_WIDTH-1:0] ar,
   input  logic signed [AMP_WIDTH-1:0] ai,
   input  logic signed [AMP_WIDTH-1:0] entry_re,
   input  logic signed [AMP_WIDTH-1:0] entry_im,
   output logic signed [AMP_WIDTH-1:0] sum_re,
   output logic signed [AMP_WIDTH-1:0] sum_im,
   output logic                        sat
);

   localparam logic signed [DIFF_W:0] RND_HALF = (DIFF_W+1)'(1) << (RND_SHIFT - 1);
   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(AMP_MAX);
   localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(AMP_MIN);

   logic signed [PROD_W-1:0] cr_x, ci_x, ar_x, ai_x;
   logic signed [PROD_W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [DIFF_W-1:0] diff_re, diff_im;
   logic signed [DIFF_W:0]   half_re, half_im;
   logic signed [RND_W-1:0]  rnd_re_ff, rnd_im_ff;
   logic signed [ACC_W-1:0]  acc_re, acc_im;
   logic                     sat_re, sat_im;

   assign cr_x = PROD_W'(cr);
   assign ci_x = PROD_W'(ci);
   assign ar_x = PROD_W'(ar);
   assign ai_x = PROD_W'(ai);

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         p_rr_ff <= cr_x * ar_x;
         p_ii_ff <= ci_x * ai_x;
         p_ri_ff <= cr_x * ai_x;
         p_ir_ff <= ci_x * ar_x;
      end
      if (ctrl.rnd_en) begin
         rnd_re_ff <= half_re[DIFF_W:RND_SHIFT];
         rnd_im_ff <= half_im[DIFF_W:RND_SHIFT];
      end
   end

   // round half up: add half an LSB, then floor by the arithmetic shift
   always_comb begin
      diff_re = DIFF_W'(p_rr_ff) - DIFF_W'(p_ii_ff);
      diff_im = DIFF_W'(p_ri_ff) + DIFF_W'(p_ir_ff);
      half_re = (DIFF_W+1)'(diff_re) + RND_HALF;
      half_im = (DIFF_W+1)'(diff_im) + RND_HALF;
   end

   always_comb begin
      acc_re = ACC_W'(entry_re) + ACC_W'(rnd_re_ff);
      acc_im = ACC_W'(entry_im) + ACC_W'(rnd_im_ff);
      sat_re = (acc_re > ACC_MAX) || (acc_re < ACC_MIN);
      sat_im = (acc_im > ACC_MAX) || (acc_im < ACC_MIN);
      if (acc_re > ACC_MAX) begin
         sum_re = AMP_MAX;
      end else if (acc_re < ACC_MIN) begin
         sum_re = AMP_MIN;
      end else begin
         sum_re = acc_re[AMP_WIDTH-1:0];
      end
      if (acc_im > ACC_MAX) begin
         sum_im = AMP_MAX;
      end else if (acc_im < ACC_MIN) begin
         sum_im = AMP_MIN;
      end else begin
         sum_im = acc_im[AMP_WIDTH-1:0];
      end
      sat = sat_re || sat_im;
   end

endmodule

// ===== design/pauli_string_matvec_accumulate.sv =====
// ----------------------------------------------------------------------------
// pauli_string_matvec_accumulate
// Scaled Pauli string applied to streamed amplitudes, accumulated into a
// stored complex vector; write and read requests load and return entries.
// ----------------------------------------------------------------------------
// Sequence: the stored entry is read as the request is accepted, then the request passes
//   the multiply, round and write-back states; the response register loads on leaving
//   write-back. Requests are taken one at a time: a new one waits until the engine is idle.
// A held response does not block the next request; a second finished one waits.
// Reset: synchronous; clears control and loads the register defaults
//   (masks 0, coefficient 1.0). Store contents stay undefined until written.
module pauli_string_matvec_accumulate
   import psma_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_operation,
   input  logic [INDEX_BITS-1:0]       req_index,
   input  logic signed [AMP_WIDTH-1:0] req_amp_re,
   input  logic signed [AMP_WIDTH-1:0] req_amp_im,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [INDEX_BITS-1:0]       rsp_target_index,
   output logic signed [AMP_WIDTH-1:0] rsp_value_re,
   output logic signed [AMP_WIDTH-1:0] rsp_value_im,
   output logic                        rsp_saturated,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_RND, ST_WB} state_type;

   state_type                   state_ff, state_in;
   op_type                      op_ff, op_in;
   logic [INDEX_BITS-1:0]       tgt_ff, tgt_in;
   logic signed [AMP_WIDTH-1:0] ar_ff, ar_in, ai_ff, ai_in;
   logic signed [CW-1:0]        cr_ff, cr_in, ci_ff, ci_in;
   logic [INDEX_BITS-1:0]       flip_ff, flip_in, ymask_ff, ymask_in, zmask_ff, zmask_in;
   logic signed [COEFF_WIDTH-1:0] cre_ff, cre_in, cim_ff, cim_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]       rsp_tgt_ff, rsp_tgt_in;
   logic signed [AMP_WIDTH-1:0] rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;
   logic                        rsp_sat_ff, rsp_sat_in;

   logic                        accept, out_free;
   logic [INDEX_BITS-1:0]       tgt_calc;
   logic [1:0]                  ycount, phase;
   logic signed [CW-1:0]        cre_x, cim_x;
   logic                        wr_en;
   logic [ENTRY_W-1:0]          wr_data, rd_data;
   logic signed [AMP_WIDTH-1:0] entry_re, entry_im, sum_re, sum_im;
   logic signed [AMP_WIDTH-1:0] val_re, val_im;
   logic                        sum_sat;
   arith_ctrl_type              actrl;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_index = rsp_tgt_ff;
   assign rsp_value_re     = rsp_re_ff;
   assign rsp_value_im     = rsp_im_ff;
   assign rsp_saturated    = rsp_sat_ff;

   assign entry_re = rd_data[ENTRY_W-1:AMP_WIDTH];
   assign entry_im = rd_data[AMP_WIDTH-1:0];

   // phase: i^popcount(Y), turned by half a circle on odd parity of (Y|Z)&index
   always_comb begin
      ycount = 2'd0;
      for (int k = 0; k < INDEX_BITS; k++) begin
         ycount = ycount + 2'(ymask_ff[k]);
      end
      phase = ycount + {^((ymask_ff | zmask_ff) & req_index), 1'b0};
      cre_x = CW'(cre_ff);
      cim_x = CW'(cim_ff);
      tgt_calc = (req_operation == OP_ACC) ? (req_index ^ flip_ff) : req_index;
   end

   always_comb begin
      case (op_ff)
         OP_ACC: begin
            val_re = sum_re;
            val_im = sum_im;
         end
         OP_WRITE: begin
            val_re = ar_ff;
            val_im = ai_ff;
         end
         default: begin
            val_re = entry_re;
            val_im = entry_im;
         end
      endcase
      wr_en   = (state_ff == ST_WB) && out_free && ((op_ff == OP_ACC) || (op_ff == OP_WRITE));
      wr_data = {val_re, val_im};
      actrl.mul_en = (state_ff == ST_MUL);
      actrl.rnd_en = (state_ff == ST_RND);
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tgt_in       = tgt_ff;
      ar_in        = ar_ff;
      ai_in        = ai_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      flip_in      = flip_ff;
      ymask_in     = ymask_ff;
      zmask_in     = zmask_ff;
      cre_in       = cre_ff;
      cim_in       = cim_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_tgt_in   = rsp_tgt_ff;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_sat_in   = rsp_sat_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_FLIP:     flip_in  = csr_wdata[INDEX_BITS-1:0];
            CSR_Y:        ymask_in = csr_wdata[INDEX_BITS-1:0];
            CSR_Z:        zmask_in = csr_wdata[INDEX_BITS-1:0];
            CSR_COEFF_RE: cre_in   = csr_wdata[COEFF_WIDTH-1:0];
            CSR_COEFF_IM: cim_in   = csr_wdata[COEFF_WIDTH-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_operation;
               tgt_in = tgt_calc;
               ar_in  = req_amp_re;
               ai_in  = req_amp_im;
               case (phase)
                  2'd0: begin
                     cr_in = cre_x;
                     ci_in = cim_x;
                  end
                  2'd1: begin
                     cr_in = -cim_x;
                     ci_in = cre_x;
                  end
                  2'd2: begin
                     cr_in = -cre_x;
                     ci_in = -cim_x;
                  end
                  default: begin
                     cr_in = cim_x;
                     ci_in = -cre_x;
                  end
               endcase
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_RND;
         ST_RND: state_in = ST_WB;
         ST_WB: begin
            // hold the finished request until the response register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_tgt_in   = tgt_ff;
               rsp_re_in    = val_re;
               rsp_im_in    = val_im;
               rsp_sat_in   = (op_ff == OP_ACC) && sum_sat;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         flip_ff      <= '0;
         ymask_ff     <= '0;
         zmask_ff     <= '0;
         cre_ff       <= COEFF_RE_RESET;
         cim_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         flip_ff      <= flip_in;
         ymask_ff     <= ymask_in;
         zmask_ff     <= zmask_in;
         cre_ff       <= cre_in;
         cim_ff       <= cim_in;
      end
      op_ff      <= op_in;
      tgt_ff     <= tgt_in;
      ar_ff      <= ar_in;
      ai_ff      <= ai_in;
      cr_ff      <= cr_in;
      ci_ff      <= ci_in;
      rsp_tgt_ff <= rsp_tgt_in;
      rsp_re_ff  <= rsp_re_in;
      rsp_im_ff  <= rsp_im_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   psma_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tgt_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (tgt_calc),
      .rd_data (rd_data)
   );

   psma_arith u_arith (
      .clock    (clock),
      .ctrl     (actrl),
      .cr       (cr_ff),
      .ci       (ci_ff),
      .ar       (ar_ff),
      .ai       (ai_ff),
      .entry_re (entry_re),
      .entry_im (entry_im),
      .sum_re   (sum_re),
      .sum_im   (sum_im),
      .sat      (sum_sat)
   );

endmodule

// ===== design/psma_checker.sv =====
// ----------------------------------------------------------------------------
// psma_checker
// Port-level checks of the Pauli string accumulate block, bound to the top.
// ----------------------------------------------------------------------------
module psma_checker
   import psma_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [INDEX_BITS-1:0]       rsp_target_index,
   input logic signed [AMP_WIDTH-1:0] rsp_value_re,
   input logic signed [AMP_WIDTH-1:0] rsp_value_im,
   input logic                        rsp_saturated
);

   // no response comes out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // one request at a time: the engine is busy after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while engine busy");

   // a clipped accumulation lands on a range limit
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_value_re == AMP_MAX || rsp_value_re == AMP_MIN ||
          rsp_value_im == AMP_MAX || rsp_value_im == AMP_MIN))
      else $error("saturated flag without a clipped value");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_target_index) && $stable(rsp_value_re) &&
          $stable(rsp_value_im) && $stable(rsp_saturated)))
      else $error("stalled response changed");

endmodule

bind pauli_string_matvec_accumulate psma_checker u_psma_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_target_index (rsp_target_index),
   .rsp_value_re     (rsp_value_re),
   .rsp_value_im     (rsp_value_im),
   .rsp_saturated    (rsp_saturated)
);

// ===== tb/pauli_accumulate_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pauli_accumulate_checker
// Watches the request, response and register channels of the Pauli string
// accumulate block. It keeps its own copy of the mask and coefficient
// registers and of the amplitude store, predicts each response as its request
// is accepted and compares the responses in order, field by field.
// ----------------------------------------------------------------------------
module pauli_accumulate_checker
   import psma_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [1:0]                  req_operation,
   input  logic [INDEX_BITS-1:0]       req_index,
   input  logic signed [AMP_WIDTH-1:0] req_amp_re,
   input  logic signed [AMP_WIDTH-1:0] req_amp_im,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [INDEX_BITS-1:0]       rsp_target_index,
   input  logic signed [AMP_WIDTH-1:0] rsp_value_re,
   input  logic signed [AMP_WIDTH-1:0] rsp_value_im,
   input  logic                        rsp_saturated,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   output int                          fail_count,
   output int                          pending_results
);

   localparam int MIX_W = 44;

   typedef struct {
      logic [INDEX_BITS-1:0]       target;
      logic signed [AMP_WIDTH-1:0] value_re;
      logic signed [AMP_WIDTH-1:0] value_im;
      logic                        saturated;
   } entry_outcome_type;

   logic [INDEX_BITS-1:0]         cfg_flip;
   logic [INDEX_BITS-1:0]         cfg_y;
   logic [INDEX_BITS-1:0]         cfg_z;
   logic signed [COEFF_WIDTH-1:0] cfg_coeff_re;
   logic signed [COEFF_WIDTH-1:0] cfg_coeff_im;

   logic signed [AMP_WIDTH-1:0] amp_store_re [DEPTH];
   logic signed [AMP_WIDTH-1:0] amp_store_im [DEPTH];

   entry_outcome_type entry_outcomes [$];

   // clamp one accumulated part to the amplitude range, flag any clip
   function automatic logic signed [AMP_WIDTH-1:0] clip_amp(
      input logic signed [MIX_W-1:0] sum, inout logic clipped);
      if (sum > MIX_W'(AMP_MAX)) begin
         clipped = 1'b1;
         return AMP_MAX;
      end
      if (sum < MIX_W'(AMP_MIN)) begin
         clipped = 1'b1;
         return AMP_MIN;
      end
      return sum[AMP_WIDTH-1:0];
   endfunction

   function automatic entry_outcome_type apply_request(
      input logic [1:0]                  op,
      input logic [INDEX_BITS-1:0]       idx,
      input logic signed [AMP_WIDTH-1:0] ar,
      input logic signed [AMP_WIDTH-1:0] ai);
      entry_outcome_type     outcome;
      logic [1:0]            quarter;
      logic signed [CW-1:0]  wide_re;
      logic signed [CW-1:0]  wide_im;
      logic signed [CW-1:0]  rot_re;
      logic signed [CW-1:0]  rot_im;
      logic signed [MIX_W-1:0] mix_re;
      logic signed [MIX_W-1:0] mix_im;
      logic [INDEX_BITS-1:0] tgt;
      logic                  clipped;
      tgt     = idx;
      clipped = 1'b0;
      if (op == OP_ACC) begin
         wide_re = CW'(cfg_coeff_re);
         wide_im = CW'(cfg_coeff_im);
         quarter = 2'($countones(cfg_y));
         // odd parity of the Y and Z qubits set in the source index negates
         if ($countones((cfg_y | cfg_z) & idx) % 2 == 1)
            quarter = quarter + 2'd2;
         case (quarter)
            2'd0: begin
               rot_re = wide_re;
               rot_im = wide_im;
            end
            2'd1: begin
               rot_re = -wide_im;
               rot_im = wide_re;
            end
            2'd2: begin
               rot_re = -wide_re;
               rot_im = -wide_im;
            end
            default: begin
               rot_re = wide_im;
               rot_im = -wide_re;
            end
         endcase
         mix_re = MIX_W'(rot_re) * MIX_W'(ar) - MIX_W'(rot_im) * MIX_W'(ai);
         mix_im = MIX_W'(rot_re) * MIX_W'(ai) + MIX_W'(rot_im) * MIX_W'(ar);
         // round half up: add half an LSB, floor shift
         mix_re = (mix_re + MIX_W'(2048)) >>> RND_SHIFT;
         mix_im = (mix_im + MIX_W'(2048)) >>> RND_SHIFT;
         tgt = idx ^ cfg_flip;
         mix_re = mix_re + MIX_W'(amp_store_re[tgt]);
         mix_im = mix_im + MIX_W'(amp_store_im[tgt]);
         amp_store_re[tgt] = clip_amp(mix_re, clipped);
         amp_store_im[tgt] = clip_amp(mix_im, clipped);
      end else if (op == OP_WRITE) begin
         amp_store_re[tgt] = ar;
         amp_store_im[tgt] = ai;
      end
      outcome.target    = tgt;
      outcome.value_re  = amp_store_re[tgt];
      outcome.value_im  = amp_store_im[tgt];
      outcome.saturated = clipped;
      return outcome;
   endfunction

   always @(posedge clock) begin
      entry_outcome_type want;
      if (reset) begin
         cfg_flip     = '0;
         cfg_y        = '0;
         cfg_z        = '0;
         cfg_coeff_re = COEFF_RE_RESET;
         cfg_coeff_im = '0;
         entry_outcomes.delete();
         pending_results = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (entry_outcomes.size() == 0) begin
               $display("%0t: response for entry %0d with no request outstanding",
                        $time, rsp_target_index);
               fail_count++;
            end else begin
               want = entry_outcomes.pop_front();
               if (rsp_target_index !== want.target) begin
                  $display("%0t: target_index expected %0d actual %0d",
                           $time, want.target, rsp_target_index);
                  fail_count++;
               end
               if (rsp_value_re !== want.value_re) begin
                  $display("%0t: value_re expected %0d actual %0d",
                           $time, want.value_re, rsp_value_re);
                  fail_count++;
               end
               if (rsp_value_im !== want.value_im) begin
                  $display("%0t: value_im expected %0d actual %0d",
                           $time, want.value_im, rsp_value_im);
                  fail_count++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $display("%0t: saturated expected %0b actual %0b",
                           $time, want.saturated, rsp_saturated);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FLIP:     cfg_flip     = csr_wdata[INDEX_BITS-1:0];
               CSR_Y:        cfg_y        = csr_wdata[INDEX_BITS-1:0];
               CSR_Z:        cfg_z        = csr_wdata[INDEX_BITS-1:0];
               CSR_COEFF_RE: cfg_coeff_re = csr_wdata[COEFF_WIDTH-1:0];
               CSR_COEFF_IM: cfg_coeff_im = csr_wdata[COEFF_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            entry_outcomes.push_back(apply_request(req_operation, req_index,
                                                   req_amp_re, req_amp_im));
         pending_results = entry_outcomes.size();
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the Pauli string accumulate block: a directed run over extreme
// amplitudes, coefficients, masks and every operation code, then phases of
// random requests under extreme, then random register settings; most phases add
// random idle gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module testbench;
   import psma_pkg::*;

   localparam op_type        OP_SPARE       = 2'd3;
   localparam csr_index_type CSR_SPARE      = 3'd7;
   localparam int            WATCHDOG_LIMIT = 4000;
   localparam int            PHASES         = 8;
   localparam int            PHASE_ITEMS    = 130;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [1:0]                  req_operation;
   logic [INDEX_BITS-1:0]       req_index;
   logic signed [AMP_WIDTH-1:0] req_amp_re;
   logic signed [AMP_WIDTH-1:0] req_amp_im;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [INDEX_BITS-1:0]       rsp_target_index;
   logic signed [AMP_WIDTH-1:0] rsp_value_re;
   logic signed [AMP_WIDTH-1:0] rsp_value_im;
   logic                        rsp_saturated;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;

   int fail_count;
   int pending_results;
   int quiet_cycles = 0;
   int stall_left   = 0;

   bit                    gaps_on   = 1'b1;
   bit                    stalls_on = 1'b1;
   bit                    written [DEPTH];
   int                    written_list [$];
   logic [INDEX_BITS-1:0] cur_flip = '0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   pauli_string_matvec_accumulate dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_index        (req_index),
      .req_amp_re       (req_amp_re),
      .req_amp_im       (req_amp_im),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_target_index (rsp_target_index),
      .rsp_value_re     (rsp_value_re),
      .rsp_value_im     (rsp_value_im),
      .rsp_saturated    (rsp_saturated),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   pauli_accumulate_checker scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_index        (req_index),
      .req_amp_re       (req_amp_re),
      .req_amp_im       (req_amp_im),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_target_index (rsp_target_index),
      .rsp_value_re     (rsp_value_re),
      .rsp_value_im     (rsp_value_im),
      .rsp_saturated    (rsp_saturated),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_results  (pending_results)
   );

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [AMP_WIDTH-1:0] rand_amp();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return AMP_WIDTH'($urandom());
      if (r < 75) return AMP_WIDTH'($urandom_range(0, 131071) - 65536);
      if (r < 90) begin
         case ($urandom_range(0, 4))
            0: return AMP_MAX;
            1: return AMP_MIN;
            2: return '0;
            3: return '1;
            default: return AMP_WIDTH'(1);
         endcase
      end
      if (r < 95) return AMP_MAX - AMP_WIDTH'($urandom_range(0, 255));
      return AMP_MIN + AMP_WIDTH'($urandom_range(0, 255));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_coeff();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return CSR_DATA_W'($urandom());
      if (r < 75) begin
         case ($urandom_range(0, 4))
            0: return CSR_DATA_W'(32767);
            1: return CSR_DATA_W'(-32768);
            2: return '0;
            3: return CSR_DATA_W'(4096);
            default: return CSR_DATA_W'(-4096);
         endcase
      end
      return CSR_DATA_W'($urandom_range(0, 8192) - 4096);
   endfunction

   // response side: hold ready low for random stretches
   always @(negedge clock) begin
      int g;
      if (!stalls_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         g = pick_gap();
         if (g > 0) begin
            rsp_ready  <= 1'b0;
            stall_left = g - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("pauli_string_matvec_accumulate verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [INDEX_BITS-1:0] idx,
                               input logic signed [AMP_WIDTH-1:0] re,
                               input logic signed [AMP_WIDTH-1:0] im);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_operation <= op;
      req_index     <= idx;
      req_amp_re    <= re;
      req_amp_im    <= im;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_WRITE && !written[idx]) begin
         written[idx] = 1'b1;
         written_list.push_back(int'(idx));
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drop valid and wait until every response is back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] flip, input logic [CSR_DATA_W-1:0] ym,
                            input logic [CSR_DATA_W-1:0] zm, input logic [CSR_DATA_W-1:0] cre,
                            input logic [CSR_DATA_W-1:0] cim);
      drain();
      write_csr(CSR_FLIP, flip);
      write_csr(CSR_Y, ym);
      write_csr(CSR_Z, zm);
      write_csr(CSR_COEFF_RE, cre);
      write_csr(CSR_COEFF_IM, cim);
      cur_flip = flip[INDEX_BITS-1:0];
   endtask

   // accumulate and read only touch entries already written
   task automatic random_request();
      int                    r;
      logic [INDEX_BITS-1:0] dst;
      r = $urandom_range(0, 99);
      if (written_list.size() == 0 || r < 20) begin
         send_request(OP_WRITE, INDEX_BITS'($urandom()), rand_amp(), rand_amp());
      end else begin
         dst = INDEX_BITS'(written_list[$urandom_range(0, written_list.size() - 1)]);
         if (r < 75)
            send_request(OP_ACC, dst ^ cur_flip, rand_amp(), rand_amp());
         else if (r < 95)
            send_request(OP_READ, dst, rand_amp(), rand_amp());
         else
            send_request(OP_SPARE, dst, rand_amp(), rand_amp());
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = OP_READ;
      req_index     = '0;
      req_amp_re    = '0;
      req_amp_im    = '0;
      rsp_ready     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_FLIP;
      csr_wdata     = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default registers: identity with unit coefficient
      send_request(OP_WRITE, 10'h000, '0, '0);
      send_request(OP_WRITE, 10'h3FF, AMP_MAX, AMP_MIN);
      send_request(OP_WRITE, 10'h2AA, '1, AMP_WIDTH'(1));
      send_request(OP_WRITE, 10'h155, AMP_MIN, AMP_MAX);
      send_request(OP_READ, 10'h3FF, '0, '0);
      send_request(OP_SPARE, 10'h2AA, AMP_MAX, AMP_MIN);
      send_request(OP_ACC, 10'h3FF, AMP_MAX, AMP_MAX);
      send_request(OP_ACC, 10'h000, AMP_MIN, AMP_MIN);
      send_request(OP_ACC, 10'h155, AMP_WIDTH'(1), '1);
      send_request(OP_READ, 10'h000, '0, '0);

      // all index bits flipped, odd Y count, extreme coefficient; upper mask bits ignored
      configure(16'hFFFF, 16'hFD55, 16'h02AA, CSR_DATA_W'(-32768), CSR_DATA_W'(32767));
      write_csr(CSR_SPARE, 16'hFFFF);
      send_request(OP_ACC, 10'h000, AMP_MAX, AMP_MIN);
      send_request(OP_ACC, 10'h3FF, AMP_MIN, AMP_MAX);
      send_request(OP_ACC, 10'h155, AMP_WIDTH'(1), '1);
      send_request(OP_ACC, 10'h2AA, '1, '0);
      send_request(OP_WRITE, 10'h3FF, '0, '0);
      send_request(OP_SPARE, 10'h3FF, '0, '0);

      // two Y qubits: even parity takes the negated phase
      configure('0, 16'h0003, '0, CSR_DATA_W'(32767), CSR_DATA_W'(-32768));
      send_request(OP_ACC, 10'h000, AMP_MAX, AMP_MAX);
      send_request(OP_ACC, 10'h155, AMP_MIN, AMP_WIDTH'(1));
      send_request(OP_ACC, 10'h3FF, AMP_WIDTH'(12345), AMP_WIDTH'(-54321));
      send_request(OP_READ, 10'h155, '0, '0);

      for (int p = 0; p < PHASES; p++) begin
         if (p == 0)
            configure(16'h03FF, 16'h03FF, 16'h03FF, CSR_DATA_W'(32767),
                      CSR_DATA_W'(32767));
         else if (p == 1)
            configure('0, '0, '0, CSR_DATA_W'(-32768), CSR_DATA_W'(-32768));
         else
            configure(CSR_DATA_W'($urandom()), CSR_DATA_W'($urandom()),
                      CSR_DATA_W'($urandom()), rand_coeff(), rand_coeff());
         gaps_on   = (p != 2) && ($urandom_range(0, 3) != 0);
         stalls_on = (p != 2) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_ITEMS; n++)
            random_request();
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("pauli_string_matvec_accumulate verification clean");
      else
         $display("pauli_string_matvec_accumulate verification failed");
      $finish;
   end

endmodule

// ===== pauli_string_matvec_accumulate.f =====
design/psma_pkg.sv
design/psma_ram.sv
design/psma_arith.sv
design/pauli_string_matvec_accumulate.sv
design/psma_checker.sv
tb/pauli_accumulate_checker.sv
tb/testbench.sv
